[rtl/core/assert_macros.svh]
// assertion macros used by the led matrix row scan driver rtl
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

[rtl/core/lmrsd_pkg.sv]
// package of the led matrix row scan driver: types, codes and constants
// no dependencies
package lmrsd_pkg;

	// default panel geometry
	localparam int PANEL_WIDTH_DEF  = 64;
	localparam int PANEL_HEIGHT_DEF = 32;

	// field widths
	localparam int INDEX_W = 13;
	localparam int VALUE_W = 8;
	localparam int ROW_W   = 4;
	localparam int COL_W   = 6;

	// divide by three through a reciprocal: q = (x * 10923) >> 15, exact for 13-bit x
	localparam int DIV3_MUL   = 10923;
	localparam int DIV3_MUL_W = 14;
	localparam int DIV3_SHIFT = 15;

	// input item kinds
	typedef enum logic {
		OP_WRITE   = 1'b0,
		OP_REFRESH = 1'b1
	} opcode_t;

	// colour offset inside a pixel
	typedef enum logic [1:0] {
		COLOUR_RED   = 2'd0,
		COLOUR_GREEN = 2'd1,
		COLOUR_BLUE  = 2'd2
	} colour_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WDIV,
		ST_WCOMMIT,
		ST_SCAN
	} state_t;

endpackage

[rtl/core/led_matrix_row_scan_driver.sv]
// led matrix row scan driver: a write beat steps through accept, divide by three and commit;
// a refresh beat gives PANEL_WIDTH column beats, one column per cycle unless m_tready
// stalls, through the column address incrementers and the registered frame memory reads.
// first column beat: issued in ST_SCAN, then registered; m_tready low stalls the scan.
// after arst_n a clear sweep zeroes all PANEL_WIDTH*PANEL_HEIGHT pixels of the frame memory
// (2048 by default) with s_tready low; the row pair counter resets to zero.
`include "assert_macros.svh"

module led_matrix_row_scan_driver #(
	parameter int PANEL_WIDTH  = lmrsd_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = lmrsd_pkg::PANEL_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [12:0] byte_index, [20:13] byte_value, [23:21] zero
	input  logic [23:0] s_tdata,
	// [0] opcode
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [3:0] row_address, [9:4] column, [10] red_top, [11] green_top, [12] blue_top,
	// [13] red_bottom, [14] green_bottom, [15] blue_bottom
	output logic [15:0] m_tdata,
	output logic        m_tlast
);

	localparam int HALF_H      = PANEL_HEIGHT / 2;
	localparam int PAIRS       = (HALF_H == 0) ? 1 : HALF_H;
	localparam int PIXELS      = PANEL_WIDTH * PANEL_HEIGHT;
	localparam int PIX_W       = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	localparam int FRAME_BYTES = 3 * PIXELS;
	localparam int CNT_W       = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
	localparam int PROD_W      = lmrsd_pkg::INDEX_W + lmrsd_pkg::DIV3_MUL_W;
	localparam int PIXQ_W      = PROD_W - lmrsd_pkg::DIV3_SHIFT;

	// sequencer and control registers
	lmrsd_pkg::state_t state_q, state_d;
	logic [PIX_W-1:0]             clr_q;
	logic [lmrsd_pkg::ROW_W-1:0]  row_q;
	logic [CNT_W-1:0]             col_q;
	logic [PIX_W-1:0]             top_addr_q;
	logic [PIX_W-1:0]             bot_addr_q;
	logic                         m_valid_q;

	// write path registers
	logic [lmrsd_pkg::INDEX_W-1:0] idx_q;
	logic                          val_nz_q;
	logic [PIXQ_W-1:0]             pix_q;

	// output payload registers
	logic [lmrsd_pkg::ROW_W-1:0]   row_out_q;
	logic [lmrsd_pkg::COL_W-1:0]   col_out_q;
	logic                          last_out_q;
	logic [2:0]                    top_flags_q;
	logic [2:0]                    bot_flags_q;

	// combinational control
	logic                          advance;
	logic                          issue;
	logic                          last_col;
	logic                          clr_done;
	logic                          wr_en;
	logic [2:0]                    wr_mask;
	logic [PIX_W-1:0]              wr_addr;
	logic                          wr_bit;
	logic [PROD_W-1:0]             prod;
	logic [lmrsd_pkg::INDEX_W-1:0] tri_idx;
	logic [lmrsd_pkg::INDEX_W-1:0] colour_full;
	logic                          idx_ok;

	assign advance  = !m_valid_q || m_tready;
	assign issue    = (state_q == lmrsd_pkg::ST_SCAN) && advance;
	assign last_col = (col_q == CNT_W'(PANEL_WIDTH - 1));
	assign clr_done = (clr_q == PIX_W'(PIXELS - 1));

	// divide the byte index by three: pixel index and colour offset
	assign prod        = PROD_W'(idx_q) * PROD_W'(lmrsd_pkg::DIV3_MUL);
	assign tri_idx     = lmrsd_pkg::INDEX_W'({pix_q, 1'b0}) + lmrsd_pkg::INDEX_W'(pix_q);
	assign colour_full = idx_q - tri_idx;
	assign idx_ok      = (idx_q < lmrsd_pkg::INDEX_W'(FRAME_BYTES));

	// next state and memory write control
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		wr_en    = 1'b0;
		wr_mask  = 3'b000;
		wr_addr  = clr_q;
		wr_bit   = 1'b0;
		unique case (state_q)
			lmrsd_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_mask = 3'b111;
				if (clr_done) begin
					state_d = lmrsd_pkg::ST_IDLE;
				end
			end
			lmrsd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (lmrsd_pkg::opcode_t'(s_tuser) == lmrsd_pkg::OP_REFRESH) begin
						state_d = lmrsd_pkg::ST_SCAN;
					end else begin
						state_d = lmrsd_pkg::ST_WDIV;
					end
				end
			end
			lmrsd_pkg::ST_WDIV: begin
				state_d = lmrsd_pkg::ST_WCOMMIT;
			end
			lmrsd_pkg::ST_WCOMMIT: begin
				wr_en   = idx_ok;
				wr_addr = PIX_W'(pix_q);
				wr_bit  = val_nz_q;
				case (lmrsd_pkg::colour_t'(colour_full[1:0]))
					lmrsd_pkg::COLOUR_RED:   wr_mask = 3'b001;
					lmrsd_pkg::COLOUR_GREEN: wr_mask = 3'b010;
					lmrsd_pkg::COLOUR_BLUE:  wr_mask = 3'b100;
					default:                 wr_mask = 3'b000;
				endcase
				state_d = lmrsd_pkg::ST_IDLE;
			end
			lmrsd_pkg::ST_SCAN: begin
				if (issue && last_col) begin
					state_d = lmrsd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lmrsd_pkg::ST_CLEAR;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmrsd_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// clear sweep, row pair counter, column counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			row_q     <= '0;
			col_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == lmrsd_pkg::ST_CLEAR) begin
				clr_q <= clr_q + PIX_W'(1);
			end
			if (s_tvalid && s_tready) begin
				col_q <= '0;
			end else if (issue) begin
				col_q <= col_q + CNT_W'(1);
			end
			if (issue && last_col) begin
				row_q <= (row_q == lmrsd_pkg::ROW_W'(PAIRS - 1)) ? '0
					: row_q + lmrsd_pkg::ROW_W'(1);
			end
			if (advance) begin
				m_valid_q <= issue;
			end
		end
	end

	// scan addresses and latched write fields
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			idx_q      <= s_tdata[lmrsd_pkg::INDEX_W-1:0];
			val_nz_q   <= |s_tdata[lmrsd_pkg::INDEX_W +: lmrsd_pkg::VALUE_W];
			top_addr_q <= PIX_W'(int'(row_q) * PANEL_WIDTH);
			bot_addr_q <= PIX_W'((int'(row_q) + HALF_H) * PANEL_WIDTH);
		end else if (issue) begin
			top_addr_q <= top_addr_q + PIX_W'(1);
			bot_addr_q <= bot_addr_q + PIX_W'(1);
		end
		if (state_q == lmrsd_pkg::ST_WDIV) begin
			pix_q <= prod[PROD_W-1:lmrsd_pkg::DIV3_SHIFT];
		end
	end

	// output beat fields other than the colour flags
	always_ff @(posedge clk) begin
		if (issue) begin
			row_out_q  <= row_q;
			col_out_q  <= lmrsd_pkg::COL_W'(col_q);
			last_out_q <= last_col;
		end
	end

	// frame memory: one bank per colour, one write port, top and bottom read ports
	for (genvar g = 0; g < 3; g++) begin : g_bank
		logic mem [PIXELS];

		always_ff @(posedge clk) begin
			if (wr_en && wr_mask[g]) begin
				mem[wr_addr] <= wr_bit;
			end
			if (issue) begin
				top_flags_q[g] <= mem[top_addr_q];
				bot_flags_q[g] <= mem[bot_addr_q];
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = last_out_q;
	assign m_tdata  = {bot_flags_q, top_flags_q, col_out_q, row_out_q};

	// checks
	`ASSERT_CLK(a_last_col, m_tvalid && m_tlast |-> col_out_q == lmrsd_pkg::COL_W'(PANEL_WIDTH - 1), "latch beat not on last column")
	`ASSERT_NEVER(a_row_range, row_q > lmrsd_pkg::ROW_W'(PAIRS - 1), "row pair counter out of range")
	`ASSERT_NEVER(a_clear_quiet, state_q == lmrsd_pkg::ST_CLEAR && (m_tvalid || s_tready), "activity during clear sweep")
	`ASSERT_CLK(a_row_step, issue && last_col |=> row_q != $past(row_q) || PAIRS == 1, "row pair did not advance")

endmodule

[sim/led_matrix_row_scan_driver_checker.sv]
`timescale 1ns / 100ps
// checker for the led matrix row scan driver: watches both streams, keeps its own
// frame flags and row pair counter, and compares every column beat; needs lmrsd_pkg
module led_matrix_row_scan_driver_checker #(
	parameter int PANEL_WIDTH  = lmrsd_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = lmrsd_pkg::PANEL_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// [12:0] byte_index, [20:13] byte_value, [23:21] zero
	input  logic [23:0] s_tdata,
	// [0] opcode
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// [3:0] row_address, [9:4] column, [10] red_top, [11] green_top, [12] blue_top,
	// [13] red_bottom, [14] green_bottom, [15] blue_bottom
	input  logic [15:0] m_tdata,
	input  logic        m_tlast,
	output int          errors,
	output int          pending
);

	localparam int FRAME_BYTES = PANEL_WIDTH * PANEL_HEIGHT * 3;
	localparam int HALF        = PANEL_HEIGHT / 2;
	localparam int PAIRS       = (HALF == 0) ? 1 : HALF;
	localparam int FLAG_LSB    = lmrsd_pkg::ROW_W + lmrsd_pkg::COL_W;

	typedef struct packed {
		logic [lmrsd_pkg::ROW_W-1:0] row_address;
		logic [lmrsd_pkg::COL_W-1:0] column;
		logic             red_top;
		logic             green_top;
		logic             blue_top;
		logic             red_bottom;
		logic             green_bottom;
		logic             blue_bottom;
		logic             latch_row;
	} column_beat_t;

	bit           byte_lit [FRAME_BYTES];
	logic [lmrsd_pkg::ROW_W-1:0] scan_pair;
	column_beat_t expected_columns [$];
	int           fail_count = 0;

	assign errors = fail_count;

	// flag of one colour byte, dark beyond the frame
	function automatic bit lit_at(int idx);
		return (idx < FRAME_BYTES) ? byte_lit[idx] : 1'b0;
	endfunction

	// a write keeps only whether the byte is nonzero
	task automatic store_byte(input logic [lmrsd_pkg::INDEX_W-1:0] idx,
		input logic [lmrsd_pkg::VALUE_W-1:0] val);
		if (int'(idx) < FRAME_BYTES)
			byte_lit[idx] = (val != '0);
	endtask

	// one beat per column of the current row pair, then step the pair counter
	task automatic scan_row_pair();
		column_beat_t beat;
		int row;
		int top_base;
		int bot_base;
		int t;
		int b;
		row = int'(scan_pair) % PAIRS;
		top_base = row * PANEL_WIDTH * 3;
		bot_base = (row + HALF) * PANEL_WIDTH * 3;
		for (int c = 0; c < PANEL_WIDTH; c++) begin
			t = top_base + c * 3;
			b = bot_base + c * 3;
			beat.row_address  = row[lmrsd_pkg::ROW_W-1:0];
			beat.column       = c[lmrsd_pkg::COL_W-1:0];
			beat.red_top      = lit_at(t + int'(lmrsd_pkg::COLOUR_RED));
			beat.green_top    = lit_at(t + int'(lmrsd_pkg::COLOUR_GREEN));
			beat.blue_top     = lit_at(t + int'(lmrsd_pkg::COLOUR_BLUE));
			beat.red_bottom   = lit_at(b + int'(lmrsd_pkg::COLOUR_RED));
			beat.green_bottom = lit_at(b + int'(lmrsd_pkg::COLOUR_GREEN));
			beat.blue_bottom  = lit_at(b + int'(lmrsd_pkg::COLOUR_BLUE));
			beat.latch_row    = (c == PANEL_WIDTH - 1);
			expected_columns.push_back(beat);
		end
		t = (row + 1) % PAIRS;
		scan_pair = t[lmrsd_pkg::ROW_W-1:0];
	endtask

	function automatic bit field_ok(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// compare one output beat with the oldest expectation
	task automatic check_column_beat();
		column_beat_t want;
		bit ok;
		if (expected_columns.size() == 0) begin
			$display("%0t: column beat expected none actual tdata %h tlast %b",
				$time, m_tdata, m_tlast);
			fail_count++;
			return;
		end
		want = expected_columns.pop_front();
		ok = 1'b1;
		ok &= field_ok("row_address", want.row_address, m_tdata[lmrsd_pkg::ROW_W-1:0]);
		ok &= field_ok("column", want.column, m_tdata[FLAG_LSB-1:lmrsd_pkg::ROW_W]);
		ok &= field_ok("red_top", want.red_top, m_tdata[FLAG_LSB]);
		ok &= field_ok("green_top", want.green_top, m_tdata[FLAG_LSB+1]);
		ok &= field_ok("blue_top", want.blue_top, m_tdata[FLAG_LSB+2]);
		ok &= field_ok("red_bottom", want.red_bottom, m_tdata[FLAG_LSB+3]);
		ok &= field_ok("green_bottom", want.green_bottom, m_tdata[FLAG_LSB+4]);
		ok &= field_ok("blue_bottom", want.blue_bottom, m_tdata[FLAG_LSB+5]);
		ok &= field_ok("latch_row", want.latch_row, m_tlast);
		if (!ok)
			fail_count++;
	endtask

	// output beats are checked before a new refresh adds expectations
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (byte_lit[i])
				byte_lit[i] = 1'b0;
			scan_pair = '0;
			expected_columns.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_column_beat();
			if (s_tvalid && s_tready) begin
				if (lmrsd_pkg::opcode_t'(s_tuser) == lmrsd_pkg::OP_WRITE)
					store_byte(s_tdata[lmrsd_pkg::INDEX_W-1:0],
						s_tdata[lmrsd_pkg::INDEX_W+lmrsd_pkg::VALUE_W-1:lmrsd_pkg::INDEX_W]);
				else
					scan_row_pair();
			end
			pending <= expected_columns.size();
		end
	end

endmodule

[sim/led_matrix_row_scan_driver_tb.sv]
`timescale 1ns / 100ps
// testbench top of the led matrix row scan driver: clock, reset, write and refresh
// stimulus, random back pressure and the verdict; needs lmrsd_pkg and the checker
module led_matrix_row_scan_driver_tb;

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 11;
	localparam int FRAME_BYTES    = lmrsd_pkg::PANEL_WIDTH_DEF * lmrsd_pkg::PANEL_HEIGHT_DEF * 3;
	localparam int INDEX_MAX      = (1 << lmrsd_pkg::INDEX_W) - 1;
	localparam int RANDOM_ITEMS   = 350;
	localparam int SETTLE_CYCLES  = 100;
	// covers the clearing pass after reset and the longest back pressure stall
	localparam int WATCHDOG_LIMIT = 10000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	int          errors;
	int          pending;
	bit          no_gaps = 1'b0;
	int          ready_left = 0;
	int          stall;
	int          idle_cycles = 0;

	always #(HALF_PERIOD) clk = ~clk;

	led_matrix_row_scan_driver dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	led_matrix_row_scan_driver_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.errors   (errors),
		.pending  (pending)
	);

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [lmrsd_pkg::VALUE_W-1:0] pick_colour_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return '0;
		if (r == 4)
			return '1;
		return lmrsd_pkg::VALUE_W'($urandom_range(1, 255));
	endfunction

	// present one beat after an optional gap and hold it until accepted
	task automatic drive_item(input lmrsd_pkg::opcode_t op, input logic [23:0] data);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_frame_byte(input int idx, input logic [lmrsd_pkg::VALUE_W-1:0] val);
		drive_item(lmrsd_pkg::OP_WRITE, {3'b000, val, idx[lmrsd_pkg::INDEX_W-1:0]});
	endtask

	// index and value bits of a refresh are don't care, so they get noise
	task automatic refresh_row_pair();
		drive_item(lmrsd_pkg::OP_REFRESH,
			{3'b000, lmrsd_pkg::VALUE_W'($urandom), lmrsd_pkg::INDEX_W'($urandom)});
	endtask

	// hold the sender off until every column beat has come out
	task automatic wait_for_all_columns();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// receiver back pressure with long stretches of steady ready
	always @(posedge clk) begin
		if (ready_left > 0) begin
			ready_left--;
		end else if (m_tready) begin
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				ready_left = stall - 1;
			end else begin
				ready_left = $urandom_range(0, 15);
			end
		end else begin
			m_tready <= 1'b1;
			ready_left = ($urandom_range(0, 19) == 0) ? $urandom_range(150, 400)
				: $urandom_range(0, 15);
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("led_matrix_row_scan_driver_tb NOT OK");
			$finish;
		end
	end

	initial begin
		int left;
		int burst;
		int r;
		bit pressured;
		pressured = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed: blank frame, corner bytes, both halves, out of range, clearing
		refresh_row_pair();
		write_frame_byte(0, 8'hFF);
		write_frame_byte(1, 8'h01);
		write_frame_byte(2, 8'h80);
		write_frame_byte(191, 8'h7F);
		write_frame_byte(3072, 8'h02);
		write_frame_byte(3262, 8'h04);
		write_frame_byte(3071, 8'h20);
		write_frame_byte(FRAME_BYTES - 1, 8'h10);
		write_frame_byte(FRAME_BYTES, 8'hFF);
		write_frame_byte(INDEX_MAX, 8'hFF);
		write_frame_byte(1, 8'h00);
		write_frame_byte(FRAME_BYTES + 3, 8'h08);
		refresh_row_pair();
		write_frame_byte(195, 8'h40);
		write_frame_byte(3264 + 2, 8'hFF);
		refresh_row_pair();
		refresh_row_pair();
		wait_for_all_columns();

		// random: bursts of writes, mostly followed by a refresh
		left = RANDOM_ITEMS;
		while (left > 0) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			burst = $urandom_range(1, 10);
			repeat (burst) begin
				r = $urandom_range(0, 99);
				if (r < 85)
					write_frame_byte($urandom_range(0, FRAME_BYTES - 1), pick_colour_byte());
				else
					write_frame_byte($urandom_range(FRAME_BYTES, INDEX_MAX), pick_colour_byte());
				left--;
			end
			if ($urandom_range(0, 99) < 85) begin
				refresh_row_pair();
				left--;
			end
			if (!pressured && left < RANDOM_ITEMS / 2) begin
				wait_for_all_columns();
				pressured = 1'b1;
			end
		end
		no_gaps = 1'b0;

		wait_for_all_columns();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		if (errors == 0 && pending == 0)
			$display("led_matrix_row_scan_driver_tb OK");
		else
			$display("led_matrix_row_scan_driver_tb NOT OK");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/lmrsd_pkg.sv
rtl/core/led_matrix_row_scan_driver.sv
sim/led_matrix_row_scan_driver_checker.sv
sim/led_matrix_row_scan_driver_tb.sv
